### sv/bde_pkg.sv
// Package for the bipartition dropset extractor.
// Holds the shared opcode constants, the controller state type and the
// command and status structs. It depends on nothing else.
package bde_pkg;

  // Input opcodes.
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_CMP  = 1'b1;

  // Fixed field widths.
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned TAXON_OUT_W = 16;
  localparam int unsigned MAP_IN_W    = 16;
  localparam int unsigned IDX_IN_W    = 6;

  // The taxon count after reset.
  localparam logic [CFG_W-1:0] TAXON_COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PICK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } bde_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic count_step;
    logic pick;
    logic scan_step;
    logic emit_pop;
  } bde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_done;
    logic scan_last;
    logic last_out;
  } bde_status_t;

endpackage

### sv/bde_ctrl.sv
// Controller state machine of the bipartition dropset extractor.
// Sequences count, pick, scan, drain and emit phases; uses bde_pkg.
module bde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             opcode,
  input  logic             out_stall,
  input  bde_pkg::bde_status_t status,
  output logic             in_stall,
  output logic             out_valid,
  output bde_pkg::bde_cmd_t cmd
);
  import bde_pkg::*;

  bde_state_t state;
  bde_state_t state_next;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && (state == ST_IDLE);
  assign out_acc = (state == ST_EMIT) && !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (opcode == OPC_CMP)) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        if (status.count_done) state_next = ST_PICK;
      end
      ST_PICK:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_acc && status.last_out) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_stall       = (state != ST_IDLE);
    out_valid      = (state == ST_EMIT);
    cmd            = '0;
    cmd.load       = in_acc && (opcode == OPC_LOAD);
    cmd.start      = in_acc && (opcode == OPC_CMP);
    cmd.count_step = (state == ST_COUNT);
    cmd.pick       = (state == ST_PICK);
    cmd.scan_step  = (state == ST_SCAN);
    cmd.emit_pop   = out_acc;
  end

endmodule

### sv/bde_datapath.sv
// Datapath of the bipartition dropset extractor: taxon map memory,
// chunked popcount, bit scan and sorted insertion list. Uses bde_pkg.
module bde_datapath #(
  parameter int unsigned MAX_TAXA      = 64,
  parameter int unsigned TAXON_ID_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bde_pkg::bde_cmd_t                cmd,
  input  logic [bde_pkg::CFG_W-1:0]        taxon_count,
  input  logic [bde_pkg::IDX_IN_W-1:0]     map_index,
  input  logic [bde_pkg::MAP_IN_W-1:0]     map_value,
  input  logic [63:0]                      induced_bip,
  input  logic [63:0]                      small_bip,
  output bde_pkg::bde_status_t             status,
  output logic [bde_pkg::TAXON_OUT_W-1:0]  taxon_number,
  output logic                             is_matching,
  output logic                             last
);
  import bde_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_TAXA);
  localparam int unsigned CHUNKS = (MAX_TAXA + 7) / 8;
  localparam int unsigned CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned PW     = $clog2(MAX_TAXA + 1);
  localparam int unsigned LD     = MAX_TAXA / 2;
  localparam int unsigned NW     = $clog2(LD + 1);

  typedef logic [TAXON_ID_BITS-1:0] id_t;

  // Taxon map memory and its registered read port.
  id_t map_mem [MAX_TAXA];
  id_t rd_data;
  logic rd_pend;

  logic [CFG_W-1:0]      act;
  logic [MAX_TAXA-1:0]   act_mask;
  logic [MAX_TAXA-1:0]   diff;
  logic [CHUNKS*8-1:0]   cnt_sh;
  logic [CW-1:0]         chunk;
  logic [PW-1:0]         pc;
  logic [3:0]            chunk_ones;
  logic [MAX_TAXA-1:0]   sel;
  logic [AW-1:0]         idx;
  id_t                   list [LD];
  id_t                   list_ins [LD];
  logic [LD-1:0]         keep;
  logic [NW-1:0]         n;
  logic [31:0]           wr_wide;
  logic [31:0]           head_wide;
  logic                  keep_cross;

  // Active taxon count, clamped to the table size.
  always_comb begin
    if (taxon_count > CFG_W'(MAX_TAXA)) act = CFG_W'(MAX_TAXA);
    else act = taxon_count;
    for (int k = 0; k < MAX_TAXA; k++) begin
      act_mask[k] = (CFG_W'(k) < act);
    end
  end

  assign wr_wide = 32'(map_value);

  // Map memory write on a load transfer; reads come from the scan index.
  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, map_index} < 7'(MAX_TAXA))) begin
      map_mem[map_index[AW-1:0]] <= wr_wide[TAXON_ID_BITS-1:0];
    end
    rd_data <= map_mem[idx];
  end

  // Ones in the low byte of the count shifter.
  always_comb begin
    chunk_ones = '0;
    for (int b = 0; b < 8; b++) begin
      chunk_ones = chunk_ones + 4'(cnt_sh[b]);
    end
  end

  // The cross pair is kept unless AND plus NOR is strictly smaller,
  // that is unless act - pc < pc.
  assign keep_cross = !((PW+1)'(act) < ({1'b0, pc} << 1));

  // Insertion cells: entries not above the new value stay put.
  always_comb begin
    for (int j = 0; j < LD; j++) begin
      keep[j] = (NW'(j) < n) && !(list[j] > rd_data);
    end
    list_ins[0] = keep[0] ? list[0] : rd_data;
    for (int j = 1; j < LD; j++) begin
      if (keep[j]) list_ins[j] = list[j];
      else if (keep[j-1]) list_ins[j] = rd_data;
      else list_ins[j] = list[j-1];
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      n       <= '0;
      chunk   <= '0;
      idx     <= '0;
    end else begin
      rd_pend <= cmd.scan_step && sel[0];
      if (cmd.start) begin
        chunk <= '0;
      end else if (cmd.count_step) begin
        chunk <= chunk + 1'b1;
      end
      if (cmd.pick) begin
        n   <= '0;
        idx <= '0;
      end else begin
        if (cmd.scan_step) idx <= idx + 1'b1;
        if (rd_pend) begin
          n <= n + 1'b1;
        end else if (cmd.emit_pop && (n != '0)) begin
          n <= n - 1'b1;
        end
      end
    end
  end

  // Payload registers: masks, count, scan shifter and sorted list.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      diff   <= (induced_bip[MAX_TAXA-1:0] ^ small_bip[MAX_TAXA-1:0]) & act_mask;
      cnt_sh <= (CHUNKS*8)'((induced_bip[MAX_TAXA-1:0] ^ small_bip[MAX_TAXA-1:0])
                & act_mask);
      pc     <= '0;
    end else if (cmd.count_step) begin
      cnt_sh <= cnt_sh >> 8;
      pc     <= pc + PW'(chunk_ones);
    end
    if (cmd.pick) begin
      sel <= keep_cross ? diff : (~diff & act_mask);
    end else if (cmd.scan_step) begin
      sel <= sel >> 1;
    end
    if (rd_pend) begin
      for (int j = 0; j < LD; j++) list[j] <= list_ins[j];
    end else if (cmd.emit_pop) begin
      for (int j = 0; j < LD - 1; j++) list[j] <= list[j+1];
    end
  end

  // Result fields from the head of the list.
  assign head_wide    = 32'(list[0]);
  assign is_matching  = (n == '0);
  assign taxon_number = is_matching ? '0 : head_wide[TAXON_OUT_W-1:0];
  assign last         = (n <= NW'(1));

  always_comb begin
    status            = '0;
    status.count_done = (chunk == CW'(CHUNKS - 1));
    status.scan_last  = (idx == AW'(MAX_TAXA - 1));
    status.last_out   = last;
  end

endmodule

### sv/bipartition_dropset_extract.sv
// Bipartition dropset extractor. A load item (opcode 0) writes one taxon
// map entry. A compare item (opcode 1) is held while the difference mask
// is counted 8 bits a cycle, then every bit position is scanned once,
// reading the map memory and inserting the number of each selected taxon
// into a sorted list. Results then leave one per cycle while out_stall is
// low, ascending, and the next item is taken once the last result has
// been transferred.
module bipartition_dropset_extract #(
  parameter int unsigned MAX_TAXA      = 64,
  parameter int unsigned TAXON_ID_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bde_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [bde_pkg::IDX_IN_W-1:0]    map_index,
  input  logic [bde_pkg::MAP_IN_W-1:0]    map_value,
  input  logic [63:0]                     induced_bip,
  input  logic [63:0]                     small_bip,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bde_pkg::TAXON_OUT_W-1:0] taxon_number,
  output logic                            is_matching,
  output logic                            last
);
  import bde_pkg::*;

  bde_cmd_t          cmd;
  bde_status_t       status;
  logic [CFG_W-1:0]  taxon_count;

  // Taxon count register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taxon_count <= TAXON_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      taxon_count <= cfg_data;
    end
  end

  bde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bde_datapath #(
    .MAX_TAXA      (MAX_TAXA),
    .TAXON_ID_BITS (TAXON_ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .taxon_count  (taxon_count),
    .map_index    (map_index),
    .map_value    (map_value),
    .induced_bip  (induced_bip),
    .small_bip    (small_bip),
    .status       (status),
    .taxon_number (taxon_number),
    .is_matching  (is_matching),
    .last         (last)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the bipartition dropset extractor.
// It drives load and compare transfers, predicts each comparison's dropset and
// checks every result. It depends on bde_pkg and bipartition_dropset_extract.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bde_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;

  typedef struct {
    logic [15:0] num;
    logic        match;
    logic        lst;
  } dropset_t;

  typedef struct {
    logic        op;
    logic [5:0]  idx;
    logic [15:0] val;
    logic [63:0] ind;
    logic [63:0] sml;
    bit          typed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OPC_LOAD;
  logic [5:0]  map_index = '0;
  logic [15:0] map_value = '0;
  logic [63:0] induced_bip = '0;
  logic [63:0] small_bip = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] taxon_number;
  logic        is_matching;
  logic        last;

  // Testbench copy of the block state.
  logic [15:0] map_copy [64];
  logic [6:0]  taxon_count_copy;
  dropset_t    expected_dropset [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  bipartition_dropset_extract u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .map_index(map_index), .map_value(map_value),
    .induced_bip(induced_bip), .small_bip(small_bip),
    .out_valid(out_valid), .out_stall(out_stall),
    .taxon_number(taxon_number), .is_matching(is_matching), .last(last)
  );

  always #5 clk = ~clk;

  // Work out the results of one comparison and queue them.
  function automatic void predict_dropset(logic [63:0] ind, logic [63:0] sml);
    logic [63:0] keep, a, b, c, d, sel;
    logic [15:0] list [64];
    logic [15:0] v;
    int act, n, j;
    dropset_t r;
    act = (taxon_count_copy > 64) ? 64 : taxon_count_copy;
    keep = (act >= 64) ? '1 : ((64'd1 << act) - 64'd1);
    a = ind & sml & keep;
    b = ~ind & ~sml & keep;
    c = ind & ~sml & keep;
    d = ~ind & sml & keep;
    if ($countones(a) + $countones(b) < $countones(c) + $countones(d)) sel = a | b;
    else sel = c | d;
    if (sel == '0) begin
      r.num = '0; r.match = 1'b1; r.lst = 1'b1;
      expected_dropset.push_back(r);
      return;
    end
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (sel[i]) begin
        v = map_copy[i];
        j = n;
        while (j > 0 && list[j-1] > v) begin
          list[j] = list[j-1];
          j--;
        end
        list[j] = v;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.num = list[i]; r.match = 1'b0; r.lst = (i == n - 1);
      expected_dropset.push_back(r);
    end
  endfunction

  // One input transfer, with an optional random gap in front of it.
  task automatic send_item(logic op, logic [5:0] idx, logic [15:0] val,
                           logic [63:0] ind, logic [63:0] sml, bit typed);
    int gap;
    dropset_t r;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = op; map_index = idx; map_value = val;
    induced_bip = ind; small_bip = sml;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == OPC_LOAD) begin
      map_copy[idx] = val;
    end else if (typed) begin
      r.num = '0; r.match = 1'b1; r.lst = 1'b1;
      expected_dropset.push_back(r);
    end else begin
      predict_dropset(ind, sml);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write the taxon count once the block has gone idle.
  task automatic write_taxon_count(logic [6:0] value);
    wait (expected_dropset.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    taxon_count_copy = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A random item: mostly compares, with masks shaped to hit matches and ties.
  task automatic send_random;
    logic [63:0] ind, sml;
    if ($urandom_range(9) < 3) begin
      send_item(OPC_LOAD, 6'($urandom_range(63)), 16'($urandom), '0, '0, 1'b0);
    end else begin
      ind = {$urandom, $urandom};
      case ($urandom_range(4))
        0: sml = ind;
        1: sml = ~ind;
        2: sml = ind ^ (64'd1 << $urandom_range(63));
        3: begin
          ind = ind & {$urandom, $urandom} & {$urandom, $urandom};
          sml = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end
        default: sml = {$urandom, $urandom};
      endcase
      send_item(OPC_CMP, 6'($urandom), 16'($urandom), ind, sml, 1'b0);
    end
  endtask

  // Receiver stalls come in random bursts.
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(5) == 0) begin
      stall_left <= $urandom_range(9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    dropset_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_dropset.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: taxon %0d match %0b last %0b",
                   taxon_number, is_matching, last);
      end else begin
        e = expected_dropset.pop_front();
        if (taxon_number !== e.num || is_matching !== e.match || last !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected taxon %0d match %0b last %0b, got %0d %0b %0b",
                     e.num, e.match, e.lst, taxon_number, is_matching, last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows [15];
    logic [6:0] phase_count [7];
    phase_count = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd100, 7'd64};
    taxon_count_copy = TAXON_COUNT_RESET;

    // Directed rows: extremes, ties, duplicates and the top taxon.
    rows = '{
      '{OPC_CMP, 6'd0, 16'd0, 64'h0, 64'h0, 1'b1},
      '{OPC_CMP, 6'd0, 16'd0, '1, 64'h0, 1'b1},
      '{OPC_CMP, 6'd0, 16'd0, '1, '1, 1'b1},
      '{OPC_CMP, 6'd0, 16'd0, 64'h0000_0000_FFFF_FFFF, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'h1, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'h1, 64'h2, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, '1, 64'h1, 1'b0},
      '{OPC_LOAD, 6'd5, 16'hFFFF, 64'h0, 64'h0, 1'b0},
      '{OPC_LOAD, 6'd6, 16'h0000, 64'h0, 64'h0, 1'b0},
      '{OPC_LOAD, 6'd7, 16'hFFFF, 64'h0, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'hE0, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'h8000_0000_0000_0000, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1},
      '{OPC_LOAD, 6'd63, 16'd0, 64'h0, 64'h0, 1'b0},
      '{OPC_CMP, 6'd0, 16'd0, 64'h8000_0000_0000_0000, 64'h0, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole map so that no compare reads an unwritten entry.
    for (int i = 0; i < 64; i++) send_item(OPC_LOAD, 6'(i), 16'($urandom), '0, '0, 1'b0);
    foreach (rows[i])
      send_item(rows[i].op, rows[i].idx, rows[i].val, rows[i].ind, rows[i].sml, rows[i].typed);
    repeat (6) send_random();

    // Random phases under several taxon counts; the last one runs without idling.
    foreach (phase_count[p]) begin
      write_taxon_count(phase_count[p]);
      if (p == 6) quiet = 1'b1;
      repeat (5) send_random();
    end

    wait (expected_dropset.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_dropset.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### filelist.f
sv/bde_pkg.sv
sv/bde_ctrl.sv
sv/bde_datapath.sv
sv/bipartition_dropset_extract.sv
verif/tb_top.sv
